// ===== hdl/tksi_pkg.sv =====
`default_nettype none

package tksi_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam int LEVEL_W  = 8;
    localparam int AMOUNT_W = 32;
    localparam int IDX_W    = 3;
    localparam int KEY_W    = LEVEL_W + AMOUNT_W;

    typedef struct packed {
        logic                       op;
        logic [LEVEL_W-1:0]         level;
        logic signed [AMOUNT_W-1:0] amount;
        logic [IDX_W-1:0]           index;
    } t_in_word;

    typedef struct packed {
        logic                       made_cut;
        logic [IDX_W-1:0]           place;
        logic [IDX_W-1:0]           count;
        logic                       read_valid;
        logic [LEVEL_W-1:0]         read_level;
        logic signed [AMOUNT_W-1:0] read_amount;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT,
        S_FULL
    } t_ctrl_state;

    // order key: level above amount with its sign bit flipped, compared unsigned
    function automatic logic [KEY_W-1:0] order_key(input logic [LEVEL_W-1:0] lv,
                                                   input logic [AMOUNT_W-1:0] am);
        order_key = {lv, ~am[AMOUNT_W-1], am[AMOUNT_W-2:0]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tksi_ctrl.sv =====
`default_nettype none

module tksi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tksi_pkg::t_dp_cmd     o_cmd
);

    tksi_pkg::t_ctrl_state r_state;
    tksi_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tksi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            tksi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tksi_pkg::S_EXEC;
                end
            end
            tksi_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = tksi_pkg::S_OUT;
            end
            tksi_pkg::S_OUT: begin
                o_in_ready  = 1'b1;
                o_out_valid = 1'b1;
                o_cmd.capture = i_in_valid;
                priority if (i_in_valid && i_out_ready) begin
                    n_state = tksi_pkg::S_EXEC;
                end else if (i_in_valid) begin
                    n_state = tksi_pkg::S_FULL;
                end else if (i_out_ready) begin
                    n_state = tksi_pkg::S_IDLE;
                end
            end
            tksi_pkg::S_FULL: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = tksi_pkg::S_EXEC;
                end
            end
            default: begin
                n_state = tksi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tksi_dp.sv =====
`default_nettype none

module tksi_dp #(
    parameter int DEPTH = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tksi_pkg::t_dp_cmd   i_cmd,
    input  wire tksi_pkg::t_in_word  i_in_word,
    output tksi_pkg::t_out_word      o_out_word
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RN = (DEPTH < 8) ? DEPTH : 8;

    tksi_pkg::t_in_word  r_in;
    tksi_pkg::t_out_word r_out;
    tksi_pkg::t_out_word n_out;

    logic [tksi_pkg::LEVEL_W-1:0]  r_lvl [DEPTH];
    logic [tksi_pkg::AMOUNT_W-1:0] r_amt [DEPTH];
    logic [FW-1:0]                 r_fill;
    logic [FW-1:0]                 n_fill;

    logic [tksi_pkg::KEY_W-1:0] new_key;
    logic [DEPTH-1:0]           vld;
    logic [DEPTH-1:0]           take;
    logic [DEPTH-1:0]           first;
    logic [DEPTH-1:0]           sorted_ok;
    logic [PW-1:0]              pos;
    logic                       made;
    logic                       do_ins;

    assign new_key = tksi_pkg::order_key(r_in.level, r_in.amount);

    // compare cells, all in parallel
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [FW-1:0] CELL_IDX = FW'(g);
        logic [tksi_pkg::KEY_W-1:0] cell_key;
        assign cell_key = tksi_pkg::order_key(r_lvl[g], r_amt[g]);
        assign vld[g]   = CELL_IDX < r_fill;
        assign take[g]  = !vld[g] || (new_key > cell_key);
        if (g == 0) begin : g_head
            assign first[g]     = take[g];
            assign sorted_ok[g] = 1'b1;
        end else begin : g_body
            assign first[g] = take[g] && !take[g-1];
            assign sorted_ok[g] = !vld[g]
                || (tksi_pkg::order_key(r_lvl[g-1], r_amt[g-1]) >= cell_key);
        end
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                pos = pos | PW'(i);
            end
        end
    end

    assign made   = take[DEPTH-1];
    assign do_ins = i_cmd.exec && (r_in.op == tksi_pkg::OP_INSERT) && made;
    assign n_fill = (do_ins && (r_fill != FW'(DEPTH))) ? r_fill + FW'(1) : r_fill;

    always_comb begin
        n_out = '0;
        if (r_in.op == tksi_pkg::OP_INSERT) begin
            n_out.made_cut = made;
            n_out.place    = made ? 3'(pos) : '0;
            n_out.count    = 3'(n_fill);
        end else begin
            n_out.count = 3'(r_fill);
            for (int i = 0; i < RN; i++) begin
                if ((r_in.index == 3'(i)) && vld[i]) begin
                    n_out.read_valid  = 1'b1;
                    n_out.read_level  = r_lvl[i];
                    n_out.read_amount = r_amt[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
        if (do_ins) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (first[i]) begin
                    r_lvl[i] <= r_in.level;
                    r_amt[i] <= r_in.amount;
                end else if (i > 0 && take[i] && take[(i > 0) ? i - 1 : 0]) begin
                    r_lvl[i] <= r_lvl[(i > 0) ? i - 1 : 0];
                    r_amt[i] <= r_amt[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    assign o_out_word = r_out;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill beyond depth");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_fill))
        else $error("fill moved without an executed word");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &sorted_ok)
        else $error("stored entries out of order");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_in.op == tksi_pkg::OP_INSERT && !made) |-> r_fill == FW'(DEPTH))
        else $error("insert rejected while list not full");

endmodule

`default_nettype wire

// ===== hdl/top_k_sorted_insert.sv =====
`default_nettype none

// Keeps the best DEPTH entries ordered by level, then signed amount, best at rank 0;
// a new entry goes before the first entry it strictly beats, so ties stay behind
// older ones, and a full list drops its last entry or rejects one that does not beat
// it. Each word on the input is either an insert or a read at a rank; each produces
// one result word with the count. An item is first captured; then, in the exec
// state, the row of compare-and-shift cells decides every position at once and
// loads the output register. A waiting result does not block the capture of the
// next word, but a further word waits until the result is taken.
// The list is empty after reset, with no clearing pass.
module top_k_sorted_insert #(
    parameter int DEPTH = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tksi_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output tksi_pkg::t_out_word       o_out_word
);

    tksi_pkg::t_dp_cmd cmd;

    tksi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    tksi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
